### rtl/lef_pkg.sv
// lef_pkg: shared types and fixed constants of the LED fade envelope.
// No dependencies; imported by every module of the block.
package lef_pkg;

  localparam int FACTOR_W = 17;                           // Q1.16 fade factor
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;
  localparam int QUOT_W   = 16;                           // quotient bits below one
  localparam int ELAP_W   = 20;
  localparam int FADE_W   = 16;
  localparam int DIV_W    = 26;                           // fade_ms * 1000 fits here
  localparam int MS_TO_US = 1000;
  localparam int Q_DEPTH  = 32;                           // front-to-back queue
  localparam int Q_AW     = 5;
  localparam int OCC_W    = 6;

  typedef struct packed {
    logic [3:0] strip;
    logic [6:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       active;   // in range and some fade enabled: touches state
    logic       lit;      // any color component nonzero
  } item_t;

  typedef struct packed {
    item_t               it;
    logic [FACTOR_W-1:0] step;   // ramp step, saturated at one
  } q_t;

endpackage

### rtl/lef_front.sv
// lef_front: classifies accepted LEDs and computes the ramp step through a
// pipelined restoring divider (one quotient bit per stage). Uses lef_pkg.
module lef_front import lef_pkg::*; #(
  parameter int LEDS_PER_STRIP   = 94,
  parameter int STRIPS           = 10,
  parameter int ELAPSED_CLAMP_US = 100000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  item_t             in_item,
  input  logic [ELAP_W-1:0] elapsed_us,
  input  logic [FADE_W-1:0] fade_in_ms,
  input  logic [FADE_W-1:0] fade_out_ms,
  output logic              push,
  output q_t                entry
);

  localparam logic [ELAP_W-1:0] CLAMP = ELAP_W'(ELAPSED_CLAMP_US);

  // stage 0: register input, clamp time, pick divisor
  logic              v0;
  item_t             it0;
  logic [ELAP_W-1:0] e0;
  logic [FADE_W-1:0] fade0;
  // stage 1: scale divisor to microseconds
  logic              v1;
  item_t             it1;
  logic [ELAP_W-1:0] e1;
  logic [DIV_W-1:0]  d1;
  // divider pipe
  logic              vp   [0:QUOT_W];
  item_t             itp  [0:QUOT_W];
  logic              satp [0:QUOT_W];
  logic [DIV_W-1:0]  dp   [0:QUOT_W];
  logic [DIV_W-1:0]  remp [0:QUOT_W];
  logic [QUOT_W-1:0] qp   [0:QUOT_W];

  item_t cls;
  always_comb begin
    cls        = in_item;
    cls.lit    = (in_item.red | in_item.green | in_item.blue) != 8'd0;
    cls.active = (32'(in_item.strip) < 32'(STRIPS)) &&
                 (32'(in_item.led) < 32'(LEDS_PER_STRIP)) &&
                 ((fade_in_ms | fade_out_ms) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      vp[0] <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      vp[0] <= v1;
    end
    it0   <= cls;
    e0    <= (elapsed_us > CLAMP) ? CLAMP : elapsed_us;
    fade0 <= cls.lit ? fade_in_ms : fade_out_ms;
    it1   <= it0;
    e1    <= e0;
    d1    <= DIV_W'(fade0) * DIV_W'(MS_TO_US);
    // a step of one or more saturates; otherwise remainder starts below d
    itp[0]  <= it1;
    dp[0]   <= d1;
    satp[0] <= DIV_W'(e1) >= d1;
    remp[0] <= DIV_W'(e1);
    qp[0]   <= '0;
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic [DIV_W:0] r2;
    logic           ge;
    assign r2 = {remp[k], 1'b0};
    assign ge = r2 >= {1'b0, dp[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vp[k+1] <= 1'b0;
      end else begin
        vp[k+1] <= vp[k];
      end
      itp[k+1]  <= itp[k];
      dp[k+1]   <= dp[k];
      satp[k+1] <= satp[k];
      remp[k+1] <= ge ? DIV_W'(r2 - {1'b0, dp[k]}) : DIV_W'(r2);
      qp[k+1]   <= {qp[k][QUOT_W-2:0], ge};
    end
  end

  assign push       = vp[QUOT_W];
  assign entry.it   = itp[QUOT_W];
  assign entry.step = satp[QUOT_W] ? FACTOR_ONE : {1'b0, qp[QUOT_W]};

endmodule

### rtl/lef_fifo.sv
// lef_fifo: short queue between classification front and state back end.
// Uses lef_pkg for the entry type and depth.
module lef_fifo import lef_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  q_t   din,
  input  logic pop,
  output logic empty,
  output q_t   head
);

  q_t              store [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [OCC_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
    if (push) store[wptr] <= din;
  end

  assign empty = count == '0;
  assign head  = store[rptr];

endmodule

### rtl/lef_back.sv
// lef_back: per-LED state memory, ready flags, factor update and scaling.
// Clears the memory after reset; uses lef_pkg.
module lef_back import lef_pkg::*; #(
  parameter int LEDS_PER_STRIP = 94,
  parameter int STRIPS         = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  q_t          q_head,
  output logic        pop,
  output logic        clr_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_strip,
  output logic [6:0]  out_led,
  output logic [23:0] out_color,   // {blue, green, red}
  output logic        out_last
);

  localparam int N   = STRIPS * LEDS_PER_STRIP;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int SW  = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  localparam int MW  = FACTOR_W + 24;

  logic [MW-1:0] mem [0:N-1];   // {factor, r, g, b}
  logic [IW-1:0] clr_cnt;
  logic [STRIPS-1:0] ready;

  logic          en;
  logic [IW-1:0] hidx;
  // B2
  logic          v2;
  q_t            e2;
  logic [IW-1:0] idx2;
  logic [MW-1:0] rd;
  // last write, for a read issued at the same edge
  logic          wb_v;
  logic [IW-1:0] wb_idx;
  logic [MW-1:0] wb_data;
  // B3
  logic          v3;
  item_t         it3;
  logic [23:0]   c3;
  logic [FACTOR_W-1:0] f3;

  logic [MW-1:0]       cur;
  logic [FACTOR_W-1:0] f_old;
  logic [FACTOR_W:0]   f_sum;
  logic [FACTOR_W-1:0] f_new;
  logic [23:0]         c_new;
  logic                wr2;
  logic                rdy2;

  assign en   = !out_valid || out_ready;
  assign pop  = en && !q_empty && clr_done;
  assign hidx = IW'(q_head.it.strip[SW-1:0]) * IW'(LEDS_PER_STRIP) + IW'(q_head.it.led);

  // clearing pass, then normal writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (32'(clr_cnt) == N - 1) clr_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt] <= '0;
    end else if (en && v2 && wr2) begin
      mem[idx2] <= {f_new, c_new};
    end
    if (pop && q_head.it.active) rd <= mem[hidx];
  end

  // factor update
  always_comb begin
    cur   = (wb_v && wb_idx == idx2) ? wb_data : rd;
    f_old = cur[MW-1:24];
    rdy2  = ready[e2.it.strip[SW-1:0]];
    f_sum = {1'b0, f_old} + {1'b0, e2.step};
    wr2   = e2.it.active;
    c_new = {e2.it.red, e2.it.green, e2.it.blue};
    f_new = FACTOR_ONE;
    if (!e2.it.active) begin
      f_new = FACTOR_ONE;
    end else if (!rdy2) begin
      f_new = e2.it.lit ? FACTOR_ONE : '0;
    end else if (e2.it.lit) begin
      f_new = (f_sum >= {1'b0, FACTOR_ONE}) ? FACTOR_ONE : f_sum[FACTOR_W-1:0];
    end else begin
      f_new = (e2.step >= f_old) ? '0 : f_old - e2.step;
      c_new = cur[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      wb_v      <= 1'b0;
      ready     <= '0;
    end else if (en) begin
      v2        <= pop;
      v3        <= v2;
      out_valid <= v3;
      wb_v      <= v2 && wr2;
      if (v2 && e2.it.active && !rdy2 && e2.it.last) ready[e2.it.strip[SW-1:0]] <= 1'b1;
    end
    if (en) begin
      e2      <= q_head;
      idx2    <= hidx;
      wb_idx  <= idx2;
      wb_data <= {f_new, c_new};
      it3     <= e2.it;
      // first frame and pass-through show the incoming color at full scale
      c3      <= (e2.it.active && rdy2) ? c_new : {e2.it.red, e2.it.green, e2.it.blue};
      f3      <= (e2.it.active && rdy2) ? f_new : FACTOR_ONE;
      out_strip <= it3.strip;
      out_led   <= it3.led;
      out_last  <= it3.last;
      out_color[7:0]   <= 8'((25'(c3[23:16]) * 25'(f3)) >> 16);
      out_color[15:8]  <= 8'((25'(c3[15:8])  * 25'(f3)) >> 16);
      out_color[23:16] <= 8'((25'(c3[7:0])   * 25'(f3)) >> 16);
    end
  end

endmodule

### rtl/led_fade_envelope.sv
// led_fade_envelope: top level of the per-LED fade envelope.
// Instantiates lef_front, lef_fifo and lef_back; uses lef_pkg.
//
//  channel  | dir | handshake        | tdata (low bit up)                 | tuser | tlast
//  ---------+-----+------------------+------------------------------------+-------+---------
//  s_*      | in  | s_tvalid/tready  | led, red, green, blue, elapsed_us, | strip | last_led
//           |     |                  | fade_in_ms, fade_out_ms, zero pad  |       |
//  m_*      | out | m_tvalid/tready  | led_out, red_out, green_out,       | strip_out | frame_end
//           |     |                  | blue_out, zero pad                 |       |
//
// Throughput: one LED per cycle while s_tready is high. The path runs through the
// 16-stage ramp-step divider in the front, the queue, and three back stages
// (state read, factor update, color scaling).
// After reset a clearing pass zeroes the STRIPS*LEDS_PER_STRIP entries of the
// state memory (940 by default); s_tready stays low until it ends.
// The front never stalls; s_tready is held by a credit count over the queue,
// so m_tready low stalls only the back end until the queue fills.
module led_fade_envelope import lef_pkg::*; #(
  parameter int LEDS_PER_STRIP   = 94,
  parameter int STRIPS           = 10,
  parameter int ELAPSED_CLAMP_US = 100000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // led[6:0] red[14:7] green[22:15] blue[30:23]
                                 // elapsed_us[50:31] fade_in_ms[66:51] fade_out_ms[82:67]
  input  logic [3:0]  s_tuser,   // strip
  input  logic        s_tlast,   // last_led
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // led_out[6:0] red_out[14:7] green_out[22:15] blue_out[30:23]
  output logic [3:0]  m_tuser,   // strip_out
  output logic        m_tlast    // frame_end
);

  logic             accept;
  item_t            in_item;
  logic             push;
  q_t               q_in;
  logic             q_empty;
  q_t               q_head;
  logic             pop;
  logic             clr_done;
  logic [OCC_W-1:0] occ;
  logic [6:0]       led_o;
  logic [23:0]      color_o;

  // count items in the front pipe plus the queue; never overfill the queue
  assign s_tready = clr_done && (occ < OCC_W'(Q_DEPTH));
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(accept) - OCC_W'(pop);
    end
  end

  always_comb begin
    in_item.strip  = s_tuser;
    in_item.led    = s_tdata[6:0];
    in_item.red    = s_tdata[14:7];
    in_item.green  = s_tdata[22:15];
    in_item.blue   = s_tdata[30:23];
    in_item.last   = s_tlast;
    in_item.active = 1'b0;   // filled by the front classifier
    in_item.lit    = 1'b0;
  end

  lef_front #(
    .LEDS_PER_STRIP  (LEDS_PER_STRIP),
    .STRIPS          (STRIPS),
    .ELAPSED_CLAMP_US(ELAPSED_CLAMP_US)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_item    (in_item),
    .elapsed_us (s_tdata[50:31]),
    .fade_in_ms (s_tdata[66:51]),
    .fade_out_ms(s_tdata[82:67]),
    .push       (push),
    .entry      (q_in)
  );

  lef_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_in),
    .pop  (pop),
    .empty(q_empty),
    .head (q_head)
  );

  lef_back #(
    .LEDS_PER_STRIP(LEDS_PER_STRIP),
    .STRIPS        (STRIPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .clr_done (clr_done),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_strip(m_tuser),
    .out_led  (led_o),
    .out_color(color_o),
    .out_last (m_tlast)
  );

  assign m_tdata = {1'b0, color_o, led_o};

endmodule
